FILE: rtl/core/pcp_pkg.sv
// Shared widths, types and arithmetic helpers for the point in convex polygon block.
package pcp_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned CoordW = 32;
  localparam int unsigned GW = CoordW + 2;
  localparam int unsigned XW = CoordW + 3;
  localparam int unsigned HW = 18;
  localparam int unsigned AccW = 2 * XW + 2;
  localparam int unsigned VertW = 2 * CoordW;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [1:0] VerdOutside = 2'd0;
  localparam logic [1:0] VerdInside = 2'd1;
  localparam logic [1:0] VerdBoundary = 2'd2;
  localparam logic [1:0] VerdTooFew = 2'd3;

  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } xres_t;

  function automatic logic signed [GW-1:0] sext_g(input logic [CoordW-1:0] v);
    sext_g = {{2{v[CoordW-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] sext_x(input logic [CoordW-1:0] v);
    sext_x = {{3{v[CoordW-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] rel_g(input logic [CoordW-1:0] v,
                                                 input logic signed [GW-1:0] g);
    logic signed [XW-1:0] v3;
    v3 = sext_x(v);
    rel_g = (v3 <<< 1) + v3 - {g[GW-1], g};
  endfunction

  function automatic logic signed [XW-1:0] rel_p(input logic [CoordW-1:0] v,
                                                 input logic [CoordW-1:0] p);
    rel_p = sext_x(v) - sext_x(p);
  endfunction

endpackage

FILE: rtl/core/point_in_convex_polygon_binary.sv
// Top level of the point in convex polygon block: command decoder, search sequencer and output.
// A query with fewer than three vertices goes straight to the output with its verdict. A full
// query first reads the three vertices of the reference point, then runs the search steps, one
// step per halving of the vertex range, so ten steps at 1024 vertices, and ends with the edge
// test and the output. Its time is set by the cross product unit, which works out each sign on
// its one 18 by 18 multiplier, three signs per step, and by the single read port of the store.
module point_in_convex_polygon_binary #(
  parameter int unsigned MAX_VERTICES = pcp_pkg::MaxVertices
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // opcode [1:0], x_coord [33:2], y_coord [65:34], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // verdict [1:0], zeros above
);
  import pcp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DW = CW + 1;
  localparam int unsigned RK = DW | 1;
  localparam logic [RK-1:0] RECIP3 = RK'(((longint'(1) << RK) + 1) / 3);

  typedef enum logic [4:0] {
    S_IDLE, S_G0, S_G1, S_G2, S_G3, S_G4,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_B5,
    S_F0, S_F1, S_F2, S_F3, S_FIN
  } state_t;

  state_t state_r;
  logic [CW-1:0] count_r, l_r, r_r, mid_r;
  logic [CoordW-1:0] px_r, py_r;
  logic [DW-1:0] q1_r, q2_r;
  logic signed [GW-1:0] gx_r, gy_r;
  logic signed [XW-1:0] lx_r, ly_r, qx_r, qy_r, mx_r, my_r;
  logic signed [XW-1:0] cax_r, cay_r, cbx_r, cby_r;
  logic cstart_r, s0_pos_r, s1_neg_r, s1_pos_r;
  logic [1:0] verd_r, out_verd_r;
  logic out_valid_r;

  logic accept, mem_we;
  logic [AW-1:0] raddr;
  logic [VertW-1:0] rdata;
  logic [CoordW-1:0] rd_x, rd_y;
  xres_t xres;
  logic [DW+RK-1:0] prod1, prod2;
  logic [CW:0] lr_sum;
  logic s2_neg, s2_pos, go_right;

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign mem_we = accept && (in_tdata[1:0] == OpAppend) && (CW'(MAX_VERTICES) != count_r);
  assign rd_x = rdata[CoordW-1:0];
  assign rd_y = rdata[VertW-1:CoordW];
  assign prod1 = (DW + RK)'({1'b0, count_r}) * (DW + RK)'(RECIP3);
  assign prod2 = (DW + RK)'({count_r, 1'b0}) * (DW + RK)'(RECIP3);
  assign lr_sum = {1'b0, l_r} + {1'b0, r_r};
  assign s2_neg = xres.neg;
  assign s2_pos = !xres.neg && !xres.zero;

  always_comb begin
    if (s0_pos_r) begin
      go_right = !(!s1_neg_r && !s2_pos);
    end else begin
      go_right = !s1_pos_r && !s2_neg;
    end
  end

  always_comb begin
    case (state_r)
      S_G1: raddr = q1_r[AW-1:0];
      S_G2: raddr = q2_r[AW-1:0];
      S_B0, S_F0: raddr = l_r[AW-1:0];
      S_B1: raddr = mid_r[AW-1:0];
      S_F1: raddr = r_r[AW-1:0];
      default: raddr = '0;
    endcase
  end

  pcp_vmem #(.MAX_VERTICES(MAX_VERTICES)) u_vmem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(count_r[AW-1:0]),
    .wdata(in_tdata[65:2]),
    .raddr(raddr),
    .rdata(rdata)
  );

  pcp_cross u_cross (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cstart_r),
    .ax   (cax_r),
    .ay   (cay_r),
    .bx   (cbx_r),
    .by   (cby_r),
    .res  (xres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
      cstart_r <= 1'b0;
    end else begin
      cstart_r <= 1'b0;
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_tdata[1:0])
              OpAppend: begin
                if (mem_we) begin
                  count_r <= count_r + CW'(1);
                end
              end
              OpClear: count_r <= '0;
              OpQuery: begin
                px_r <= in_tdata[33:2];
                py_r <= in_tdata[65:34];
                if (count_r < CW'(3)) begin
                  verd_r <= VerdTooFew;
                  state_r <= S_FIN;
                end else begin
                  q1_r <= prod1[DW+RK-1:RK];
                  q2_r <= prod2[DW+RK-1:RK];
                  state_r <= S_G0;
                end
              end
              default: ;
            endcase
          end
        end
        S_G0: state_r <= S_G1;
        S_G1: begin
          gx_r <= sext_g(rd_x);
          gy_r <= sext_g(rd_y);
          state_r <= S_G2;
        end
        S_G2: begin
          gx_r <= gx_r + sext_g(rd_x);
          gy_r <= gy_r + sext_g(rd_y);
          state_r <= S_G3;
        end
        S_G3: begin
          gx_r <= gx_r + sext_g(rd_x);
          gy_r <= gy_r + sext_g(rd_y);
          state_r <= S_G4;
        end
        S_G4: begin
          qx_r <= rel_g(px_r, gx_r);
          qy_r <= rel_g(py_r, gy_r);
          if (rel_g(px_r, gx_r) == '0 && rel_g(py_r, gy_r) == '0) begin
            verd_r <= VerdInside;
            state_r <= S_FIN;
          end else begin
            l_r <= '0;
            r_r <= count_r;
            state_r <= S_B0;
          end
        end
        S_B0: begin
          mid_r <= lr_sum[CW:1];
          if (({1'b0, l_r} + (CW + 1)'(1)) < {1'b0, r_r}) begin
            state_r <= S_B1;
          end else begin
            if (r_r >= count_r) begin
              r_r <= r_r - count_r;
            end
            state_r <= S_F0;
          end
        end
        S_B1: begin
          lx_r <= rel_g(rd_x, gx_r);
          ly_r <= rel_g(rd_y, gy_r);
          state_r <= S_B2;
        end
        S_B2: begin
          mx_r <= rel_g(rd_x, gx_r);
          my_r <= rel_g(rd_y, gy_r);
          cax_r <= lx_r;
          cay_r <= ly_r;
          cbx_r <= rel_g(rd_x, gx_r);
          cby_r <= rel_g(rd_y, gy_r);
          cstart_r <= 1'b1;
          state_r <= S_B3;
        end
        S_B3: begin
          if (xres.done) begin
            s0_pos_r <= !xres.neg && !xres.zero;
            cbx_r <= qx_r;
            cby_r <= qy_r;
            cstart_r <= 1'b1;
            state_r <= S_B4;
          end
        end
        S_B4: begin
          if (xres.done) begin
            s1_neg_r <= xres.neg;
            s1_pos_r <= !xres.neg && !xres.zero;
            cax_r <= mx_r;
            cay_r <= my_r;
            cstart_r <= 1'b1;
            state_r <= S_B5;
          end
        end
        S_B5: begin
          if (xres.done) begin
            if (go_right) begin
              l_r <= mid_r;
            end else begin
              r_r <= mid_r;
            end
            state_r <= S_B0;
          end
        end
        S_F0: state_r <= S_F1;
        S_F1: begin
          cax_r <= rel_p(rd_x, px_r);
          cay_r <= rel_p(rd_y, py_r);
          state_r <= S_F2;
        end
        S_F2: begin
          cbx_r <= rel_p(rd_x, px_r);
          cby_r <= rel_p(rd_y, py_r);
          cstart_r <= 1'b1;
          state_r <= S_F3;
        end
        S_F3: begin
          if (xres.done) begin
            if (xres.zero) begin
              verd_r <= VerdBoundary;
            end else if (xres.neg) begin
              verd_r <= VerdOutside;
            end else begin
              verd_r <= VerdInside;
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_verd_r <= verd_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'b0, out_verd_r};

endmodule

FILE: rtl/core/pcp_vmem.sv
// Vertex store: one write port and one read port with registered read data.
module pcp_vmem #(
  parameter int unsigned MAX_VERTICES = pcp_pkg::MaxVertices
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(MAX_VERTICES)-1:0]     waddr,
  input  logic [pcp_pkg::VertW-1:0]           wdata,
  input  logic [$clog2(MAX_VERTICES)-1:0]     raddr,
  output logic [pcp_pkg::VertW-1:0]           rdata
);
  import pcp_pkg::*;

  logic [VertW-1:0] mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pcp_cross.sv
// Sequential cross product sign unit built on one 18 by 18 multiplier.
module pcp_cross (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [pcp_pkg::XW-1:0]    ax,
  input  logic signed [pcp_pkg::XW-1:0]    ay,
  input  logic signed [pcp_pkg::XW-1:0]    bx,
  input  logic signed [pcp_pkg::XW-1:0]    by,
  output pcp_pkg::xres_t                   res
);
  import pcp_pkg::*;

  logic [XW-1:0] m_ax_r, m_by_r, m_ay_r, m_bx_r;
  logic neg0_r, neg1_r, busy_r, done_r;
  logic [2:0] step_r;
  logic signed [AccW-1:0] acc_r;
  logic [XW-1:0] opa, opb;
  logic [HW-1:0] ha, hb;
  logic [2*HW-1:0] pp;
  logic [AccW-1:0] term;
  logic sub;

  function automatic logic [XW-1:0] mag(input logic signed [XW-1:0] v);
    mag = v[XW-1] ? XW'(-v) : XW'(v);
  endfunction

  always_comb begin
    opa = step_r[2] ? m_ay_r : m_ax_r;
    opb = step_r[2] ? m_bx_r : m_by_r;
    ha = step_r[1] ? HW'(opa[XW-1:HW]) : opa[HW-1:0];
    hb = step_r[0] ? HW'(opb[XW-1:HW]) : opb[HW-1:0];
    pp = ha * hb;
    case ({1'b0, step_r[1]} + {1'b0, step_r[0]})
      2'd0: term = AccW'(pp);
      2'd1: term = AccW'(pp) << HW;
      default: term = AccW'(pp) << (2 * HW);
    endcase
    sub = step_r[2] ? neg1_r : neg0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        m_ax_r <= mag(ax);
        m_by_r <= mag(by);
        m_ay_r <= mag(ay);
        m_bx_r <= mag(bx);
        neg0_r <= ax[XW-1] ^ by[XW-1];
        neg1_r <= ~(ay[XW-1] ^ bx[XW-1]);
        acc_r <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= sub ? acc_r - $signed(term) : acc_r + $signed(term);
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.neg = acc_r[AccW-1];
  assign res.zero = (acc_r == '0);

endmodule

FILE: rtl/core/pcp_checker.sv
// Port-level checker for the point in convex polygon block, bound to the top level.
module pcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);
  import pcp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result item dropped or changed while stalled.");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result item shown right after reset.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] != OpQuery && !out_tvalid |=> !out_tvalid)
    else $error("Result item produced without a query.");

endmodule

bind point_in_convex_polygon_binary pcp_checker u_pcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
